// ----- rtl/rcp_pkg.sv -----
// ----------------------------------------------------------------------------
// Rectangle pattern package
// Shared constants, types and helper functions of the rectangle pattern block.
// ----------------------------------------------------------------------------
package rcp_pkg;

  localparam int COORD_BITS = 11;
  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = (COORD_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int QBITS      = DIV_STAGES * DIV_STEP;
  localparam int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W      = 64;
  localparam int USER_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 39;
  localparam int RES_W      = 12;
  localparam int ADDR_W     = 24;

  localparam logic [CFG_IDX_W-1:0] REG_H_RES        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V_RES        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INDEXED_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECTANGLES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_LAYOUT = 3'd6;

  localparam logic [7:0] INDEX_MAX     = 8'd255;
  localparam logic [3:0] COMP_SIZE_MAX = 4'd8;
  localparam logic [3:0] BYTES_MAX     = 4'd4;

  typedef struct packed {
    logic [RES_W-1:0]      h_res;
    logic [RES_W-1:0]      v_res;
    logic                  indexed_mode;
    logic [7:0]            rectangles;
    logic [31:0]           first_color;
    logic [7:0]            color_step;
    logic [CFG_DATA_W-1:0] color_layout;
    logic [RES_W-1:0]      size_x;
    logic [RES_W-1:0]      size_y;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  inres;
    logic [QBITS-1:0]      qx;
    logic [QBITS-1:0]      qy;
    logic [RES_W-1:0]      rx;
    logic [RES_W-1:0]      ry;
  } tile_t;

  function automatic logic [31:0] low_mask(input logic [5:0] bits);
    logic [31:0] m;
    if (bits >= 6'd32) m = 32'hFFFF_FFFF;
    else m = (32'd1 << bits) - 32'd1;
    return m;
  endfunction

  // Three restoring division steps; returns {quotient bits, remainder}.
  function automatic logic [DIV_STEP+RES_W-1:0] div_chunk(input logic [RES_W-1:0] r,
                                                          input logic [DIV_STEP-1:0] bits,
                                                          input logic [RES_W-1:0] d);
    logic [RES_W:0]      t;
    logic [RES_W-1:0]    rr;
    logic [DIV_STEP-1:0] q;
    rr = r;
    q  = '0;
    for (int k = DIV_STEP - 1; k >= 0; k--) begin
      t = {rr, bits[k]};
      if (t >= {1'b0, d}) begin
        t    = t - {1'b0, d};
        q[k] = 1'b1;
      end
      rr = t[RES_W-1:0];
    end
    return {q, rr};
  endfunction

  function automatic logic [31:0] step_comp(input logic [31:0] color,
                                            input logic [3:0] size_raw,
                                            input logic [4:0] pos,
                                            input logic [7:0] add);
    logic [3:0]  size;
    logic [31:0] m32;
    logic [7:0]  m;
    logic [7:0]  c;
    size = (size_raw > COMP_SIZE_MAX) ? COMP_SIZE_MAX : size_raw;
    m32  = low_mask({2'b00, size});
    m    = m32[7:0];
    c    = 8'(color >> pos) & m;
    c    = (c + add) & m;
    return 32'(c) << pos;
  endfunction

endpackage

// ----- rtl/rcp_cfg.sv -----
// ----------------------------------------------------------------------------
// Rectangle pattern configuration
// Register file and serial divider that derives the tile width and height.
// ----------------------------------------------------------------------------
module rcp_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcp_pkg::CFG_DATA_W-1:0] cfg_data,
  output rcp_pkg::cfg_t                  cfg,
  output logic                           busy
);
  import rcp_pkg::*;

  localparam logic [3:0] CNT_LOAD = 4'(RES_W + 1);

  logic [RES_W-1:0] h_res, v_res;
  logic             indexed_mode;
  logic [7:0]       rectangles;
  logic [31:0]      first_color;
  logic [7:0]       color_step;
  logic [CFG_DATA_W-1:0] color_layout;
  logic [RES_W-1:0] dqx, dqy;
  logic [7:0]       rx, ry;
  logic [3:0]       cnt;
  logic [8:0]       tx, ty;

  assign busy      = (cnt != 4'd0);
  assign cfg_ready = !busy;

  assign tx = {rx, dqx[RES_W-1]};
  assign ty = {ry, dqy[RES_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      h_res        <= 12'd1024;
      v_res        <= 12'd768;
      indexed_mode <= 1'b1;
      rectangles   <= 8'd8;
      first_color  <= 32'd0;
      color_step   <= 8'd1;
      color_layout <= 39'd8;
      dqx          <= 12'd128;
      dqy          <= 12'd96;
      rx           <= '0;
      ry           <= '0;
      cnt          <= 4'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_H_RES:        h_res        <= cfg_data[RES_W-1:0];
          REG_V_RES:        v_res        <= cfg_data[RES_W-1:0];
          REG_INDEXED_MODE: indexed_mode <= cfg_data[0];
          REG_RECTANGLES:   rectangles   <= cfg_data[7:0];
          REG_FIRST_COLOR:  first_color  <= cfg_data[31:0];
          REG_COLOR_STEP:   color_step   <= cfg_data[7:0];
          REG_COLOR_LAYOUT: color_layout <= cfg_data;
          default: ;
        endcase
        cnt <= CNT_LOAD;
      end else if (cnt == CNT_LOAD) begin
        dqx <= h_res;
        dqy <= v_res;
        rx  <= '0;
        ry  <= '0;
        cnt <= cnt - 4'd1;
      end else if (busy) begin
        if (tx >= {1'b0, rectangles}) begin
          rx  <= 8'(tx - {1'b0, rectangles});
          dqx <= {dqx[RES_W-2:0], 1'b1};
        end else begin
          rx  <= tx[7:0];
          dqx <= {dqx[RES_W-2:0], 1'b0};
        end
        if (ty >= {1'b0, rectangles}) begin
          ry  <= 8'(ty - {1'b0, rectangles});
          dqy <= {dqy[RES_W-2:0], 1'b1};
        end else begin
          ry  <= ty[7:0];
          dqy <= {dqy[RES_W-2:0], 1'b0};
        end
        cnt <= cnt - 4'd1;
      end
    end
  end

  always_comb begin
    cfg.h_res        = h_res;
    cfg.v_res        = v_res;
    cfg.indexed_mode = indexed_mode;
    cfg.rectangles   = rectangles;
    cfg.first_color  = first_color;
    cfg.color_step   = color_step;
    cfg.color_layout = color_layout;
    cfg.size_x       = dqx;
    cfg.size_y       = dqy;
  end

endmodule

// ----- rtl/rcp_tile.sv -----
// ----------------------------------------------------------------------------
// Rectangle pattern tile finder
// Pipelined restoring divider giving the tile column and row of a pixel.
// ----------------------------------------------------------------------------
module rcp_tile (
  input  logic                           clk,
  input  logic                           rst,
  input  rcp_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rcp_pkg::COORD_BITS-1:0] x,
  input  logic [rcp_pkg::COORD_BITS-1:0] y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rcp_pkg::tile_t                 out_tile
);
  import rcp_pkg::*;

  logic  [DIV_STAGES-1:0] v;
  logic  [DIV_STAGES-1:0] rdy;
  tile_t                  st  [DIV_STAGES];
  tile_t                  nxt [DIV_STAGES];
  tile_t                  src [DIV_STAGES];

  always_comb begin
    for (int s = DIV_STAGES - 1; s >= 0; s--) begin
      if (s == DIV_STAGES - 1) rdy[s] = !v[s] || out_ready;
      else rdy[s] = !v[s] || rdy[s+1];
    end
  end

  always_comb begin
    logic [QBITS-1:0]              xp, yp;
    logic [DIV_STEP+RES_W-1:0]     cx, cy;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        src[s].x     = x;
        src[s].y     = y;
        src[s].inres = ({1'b0, x} < cfg.h_res) && ({1'b0, y} < cfg.v_res);
        src[s].qx    = '0;
        src[s].qy    = '0;
        src[s].rx    = '0;
        src[s].ry    = '0;
      end else begin
        src[s] = st[s-1];
      end
      xp = QBITS'(src[s].x);
      yp = QBITS'(src[s].y);
      cx = div_chunk(src[s].rx, xp[QBITS-1-DIV_STEP*s -: DIV_STEP], cfg.size_x);
      cy = div_chunk(src[s].ry, yp[QBITS-1-DIV_STEP*s -: DIV_STEP], cfg.size_y);
      nxt[s] = src[s];
      nxt[s].qx[QBITS-1-DIV_STEP*s -: DIV_STEP] = cx[DIV_STEP+RES_W-1:RES_W];
      nxt[s].qy[QBITS-1-DIV_STEP*s -: DIV_STEP] = cy[DIV_STEP+RES_W-1:RES_W];
      nxt[s].rx = cx[RES_W-1:0];
      nxt[s].ry = cy[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (rdy[s]) begin
        if (s == 0) v[s] <= in_valid;
        else v[s] <= v[s-1];
      end
      if (rdy[s] && ((s == 0) ? in_valid : v[s-1])) begin
        st[s] <= nxt[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v[DIV_STAGES-1];
  assign out_tile  = st[DIV_STAGES-1];

endmodule

// ----- rtl/rcp_color.sv -----
// ----------------------------------------------------------------------------
// Rectangle pattern color stages
// Computes tile color, byte address and write flags, with the output register.
// ----------------------------------------------------------------------------
module rcp_color (
  input  logic                        clk,
  input  logic                        rst,
  input  rcp_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rcp_pkg::tile_t              tile,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        write_enable,
  output logic                        index_error,
  output logic [rcp_pkg::ADDR_W-1:0]  byte_address,
  output logic [31:0]                 pixel_value,
  output logic [2:0]                  byte_count
);
  import rcp_pkg::*;

  typedef struct packed {
    logic                  in_tile;
    logic [COORD_BITS-1:0] x;
    logic [ADDR_W-1:0]     yh;
    logic [7:0]            col;
    logic [15:0]           rowrect;
    logic [7:0]            add_c;
    logic [7:0]            add_r;
    logic [7:0]            add_s;
  } c1_t;

  typedef struct packed {
    logic              in_tile;
    logic [31:0]       prod;
    logic [ADDR_W-1:0] addr;
    logic [3:0]        bytes;
    logic [7:0]        add_c;
    logic [7:0]        add_r;
    logic [7:0]        add_s;
  } c2_t;

  logic c1_v, c2_v, o_v;
  logic c1_rdy, c2_rdy, o_rdy;
  c1_t  c1, c1_next;
  c2_t  c2, c2_next;
  logic o_we, o_err;
  logic [ADDR_W-1:0] o_addr;
  logic [31:0] o_pix;
  logic [2:0]  o_cnt;
  logic [6:0]  bsum;
  logic [31:0] mask, color, dcolor;
  logic        err, we;

  assign o_rdy  = !o_v || out_ready;
  assign c2_rdy = !c2_v || o_rdy;
  assign c1_rdy = !c1_v || c2_rdy;
  assign in_ready = c1_rdy;

  always_comb begin
    logic [7:0] col8, row8;
    col8 = tile.qx[7:0];
    row8 = tile.qy[7:0];
    c1_next.in_tile = tile.inres && (cfg.rectangles != 8'd0) && (cfg.size_x != '0) &&
                      (cfg.size_y != '0) && (tile.qx < QBITS'(cfg.rectangles)) &&
                      (tile.qy < QBITS'(cfg.rectangles));
    c1_next.x       = tile.x;
    c1_next.yh      = ADDR_W'(ADDR_W'(tile.y) * ADDR_W'(cfg.h_res));
    c1_next.col     = col8;
    c1_next.rowrect = 16'(row8) * 16'(cfg.rectangles);
    c1_next.add_c   = 8'(col8 * cfg.color_step);
    c1_next.add_r   = 8'(row8 * cfg.color_step);
    c1_next.add_s   = 8'(8'(col8 + row8) * cfg.color_step);
  end

  assign bsum = 7'(cfg.color_layout[5:0]) + 7'(cfg.color_layout[11:6]);

  always_comb begin
    logic [16:0] idx;
    idx = 17'(c1.rowrect) + 17'(c1.col);
    c2_next.in_tile = c1.in_tile;
    c2_next.prod    = 32'(idx) * 32'(cfg.color_step);
    c2_next.bytes   = bsum[6:3];
    c2_next.addr    = ADDR_W'((c1.yh + ADDR_W'(c1.x)) * ADDR_W'(bsum[6:3]));
    c2_next.add_c   = c1.add_c;
    c2_next.add_r   = c1.add_r;
    c2_next.add_s   = c1.add_s;
  end

  always_comb begin
    mask   = low_mask(cfg.color_layout[5:0]);
    dcolor = step_comp(cfg.first_color, cfg.color_layout[15:12], cfg.color_layout[20:16],
                       c2.add_c) |
             step_comp(cfg.first_color, cfg.color_layout[24:21], cfg.color_layout[29:25],
                       c2.add_r) |
             step_comp(cfg.first_color, cfg.color_layout[33:30], cfg.color_layout[38:34],
                       c2.add_s);
    if (cfg.indexed_mode) color = (cfg.first_color + c2.prod) & mask;
    else color = dcolor & mask;
    err = c2.in_tile && cfg.indexed_mode && (color > 32'(INDEX_MAX));
    we  = c2.in_tile && !err && (c2.bytes != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
      o_v  <= 1'b0;
    end else begin
      if (c1_rdy) c1_v <= in_valid;
      if (c2_rdy) c2_v <= c1_v;
      if (o_rdy) o_v <= c2_v;
    end
    if (c1_rdy && in_valid) c1 <= c1_next;
    if (c2_rdy && c1_v) c2 <= c2_next;
    if (o_rdy && c2_v) begin
      o_we   <= we;
      o_err  <= err;
      o_addr <= we ? c2.addr : '0;
      o_pix  <= we ? color : 32'd0;
      o_cnt  <= we ? ((c2.bytes > BYTES_MAX) ? 3'(BYTES_MAX) : c2.bytes[2:0]) : 3'd0;
    end
  end

  assign out_valid    = o_v;
  assign write_enable = o_we;
  assign index_error  = o_err;
  assign byte_address = o_addr;
  assign pixel_value  = o_pix;
  assign byte_count   = o_cnt;

endmodule

// ----- rtl/rectangle_color_pattern_pixel.sv -----
// ----------------------------------------------------------------------------
// Rectangle color pattern pixel
// Maps one pixel coordinate to its test pattern color and frame-buffer write.
// ----------------------------------------------------------------------------
// The slave channel takes one pixel coordinate per item; the master channel
// returns one result item per input item, in order. The result carries the
// write and index error flags in tuser and the byte address, pixel value and
// byte count in tdata. Registers are written through the cfg channel.
// An accepted input item passes through seven register stages before its
// result is valid: four stages of the tile divider, which resolves three
// quotient bits per stage, two multiplier stages and the output register.
// Throughput is one item per cycle while m_tready is high and no register
// write is in progress. After each register write the tile width and height
// are recomputed by a serial divider; during that time cfg_ready and
// s_tready are low. Reset loads the default registers, whose tile size is
// ready at once, and empties the pipeline. When the receiver holds m_tready
// low the stages fill up and s_tready falls; no item is lost or repeated.
// ----------------------------------------------------------------------------
module rectangle_color_pattern_pixel (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rcp_pkg::IN_W-1:0]       s_tdata,   // x, y, zero fill
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rcp_pkg::OUT_W-1:0]      m_tdata,   // byte_address, pixel_value,
                                                    // byte_count, zero fill
  output logic [rcp_pkg::USER_W-1:0]     m_tuser,   // write_enable, index_error
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rcp_pkg::*;

  cfg_t  cfg;
  logic  busy;
  logic  tile_in_ready, tile_valid, tile_ready;
  tile_t tile;
  logic  we, err;
  logic [ADDR_W-1:0] addr;
  logic [31:0] pix;
  logic [2:0]  cnt;

  rcp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .busy      (busy)
  );

  assign s_tready = tile_in_ready && !busy;

  rcp_tile u_tile (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid && !busy),
    .in_ready  (tile_in_ready),
    .x         (s_tdata[COORD_BITS-1:0]),
    .y         (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .out_valid (tile_valid),
    .out_ready (tile_ready),
    .out_tile  (tile)
  );

  rcp_color u_color (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (tile_valid),
    .in_ready     (tile_ready),
    .tile         (tile),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .write_enable (we),
    .index_error  (err),
    .byte_address (addr),
    .pixel_value  (pix),
    .byte_count   (cnt)
  );

  assign m_tdata = {{(OUT_W - ADDR_W - 35){1'b0}}, cnt, pix, addr};
  assign m_tuser = {err, we};

endmodule

// ----- dv/pattern_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rectangle pattern checker
// Watches the pixel, result and register channels, predicts each result item
// from its own copy of the registers and compares it field by field.
// ----------------------------------------------------------------------------
module pattern_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [rcp_pkg::IN_W-1:0]       s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [rcp_pkg::OUT_W-1:0]      m_tdata,
  input  logic [rcp_pkg::USER_W-1:0]     m_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             seen_writes,
  output int                             seen_errors
);
  import rcp_pkg::*;

  typedef struct packed {
    logic        we;
    logic        err;
    logic [23:0] addr;
    logic [31:0] pix;
    logic [2:0]  cnt;
  } pixel_res_t;

  logic [11:0] h_res, v_res;
  logic        indexed;
  logic [7:0]  rects, step;
  logic [31:0] first;
  logic [38:0] layout;
  pixel_res_t  expected_pixels[$];

  function automatic logic [31:0] bit_mask(input int bits);
    if (bits >= 32) return 32'hFFFF_FFFF;
    return (32'd1 << bits) - 32'd1;
  endfunction

  function automatic logic [31:0] shift_field(input logic [31:0] c, input int size_raw,
                                              input int pos, input logic [31:0] add);
    int sz;
    logic [31:0] v;
    sz = size_raw > 8 ? 8 : size_raw;
    v = ((c >> pos) & bit_mask(sz));
    v = (v + add) & bit_mask(sz);
    return v << pos;
  endfunction

  function automatic pixel_res_t predict_pixel(input int x, input int y);
    pixel_res_t r;
    int bpp, bytes, sx, sy, col, row;
    logic in_tile;
    logic [31:0] color;
    logic [63:0] a;
    r = '0;
    in_tile = 1'b0;
    bpp = int'(layout[5:0]);
    bytes = (int'(layout[5:0]) + int'(layout[11:6])) / 8;
    col = 0;
    row = 0;
    if (rects != 0 && x < h_res && y < v_res) begin
      sx = h_res / rects;
      sy = v_res / rects;
      if (sx != 0 && sy != 0) begin
        col = x / sx;
        row = y / sy;
        in_tile = col < rects && row < rects;
      end
    end
    if (!in_tile) return r;
    if (indexed) begin
      color = first + 32'((row * rects + col) * step);
      color &= bit_mask(bpp);
      r.err = color > 255;
    end else begin
      color = shift_field(first, int'(layout[15:12]), int'(layout[20:16]), 32'(col * step))
            | shift_field(first, int'(layout[24:21]), int'(layout[29:25]), 32'(row * step))
            | shift_field(first, int'(layout[33:30]), int'(layout[38:34]),
                          32'((col + row) * step));
    end
    color &= bit_mask(bpp);
    if (!r.err && bytes != 0) begin
      a = (64'(x) + 64'(y) * h_res) * bytes;
      r.we = 1'b1;
      r.addr = a[23:0];
      r.pix = color;
      r.cnt = bytes > 4 ? 3'd4 : 3'(bytes);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pixel_res_t e;
    if (rst) begin
      h_res <= 12'd1024; v_res <= 12'd768; indexed <= 1'b1; rects <= 8'd8;
      first <= 32'd0; step <= 8'd1; layout <= 39'd8;
      expected_pixels.delete();
      fail_count = 0; seen_writes <= 0; seen_errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_H_RES:        h_res <= cfg_data[11:0];
          REG_V_RES:        v_res <= cfg_data[11:0];
          REG_INDEXED_MODE: indexed <= cfg_data[0];
          REG_RECTANGLES:   rects <= cfg_data[7:0];
          REG_FIRST_COLOR:  first <= cfg_data[31:0];
          REG_COLOR_STEP:   step <= cfg_data[7:0];
          REG_COLOR_LAYOUT: layout <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_pixels.push_back(predict_pixel(int'(s_tdata[10:0]), int'(s_tdata[21:11])));
      if (m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result item", 32'(m_tuser), 32'd0);
        end else begin
          e = expected_pixels.pop_front();
          if (m_tuser[0] != e.we)
            report_mismatch("write_enable", 32'(m_tuser[0]), 32'(e.we));
          if (m_tuser[1] != e.err)
            report_mismatch("index_error", 32'(m_tuser[1]), 32'(e.err));
          if (m_tdata[23:0] != e.addr)
            report_mismatch("byte_address", 32'(m_tdata[23:0]), 32'(e.addr));
          if (m_tdata[55:24] != e.pix)
            report_mismatch("pixel_value", m_tdata[55:24], e.pix);
          if (m_tdata[58:56] != e.cnt)
            report_mismatch("byte_count", 32'(m_tdata[58:56]), 32'(e.cnt));
          if (m_tdata[63:59] != 0)
            report_mismatch("zero fill", 32'(m_tdata[63:59]), 32'd0);
          seen_writes <= seen_writes + e.we;
          seen_errors <= seen_errors + e.err;
        end
      end
      pending <= expected_pixels.size();
    end
  end
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rectangle pattern testbench
// Drives pixel coordinates and register settings into the pattern block under
// random gaps and back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import rcp_pkg::*;

  logic                  clk, rst;
  logic                  s_tvalid, s_tready, m_tvalid, m_tready;
  logic [IN_W-1:0]       s_tdata;
  logic [OUT_W-1:0]      m_tdata;
  logic [USER_W-1:0]     m_tuser;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending, seen_writes, seen_errors;
  int phases;

  rectangle_color_pattern_pixel dut (.*);
  pattern_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int w;
    m_tready = 0;
    @(posedge clk iff !rst);
    forever begin
      m_tready <= 1;
      @(posedge clk iff m_tvalid);
      w = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6) : 0;
      if (w != 0) begin
        m_tready <= 0;
        repeat (w) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [38:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input int x, input int y);
    int w;
    s_tvalid <= 1;
    s_tdata <= {2'b00, 11'(y), 11'(x)};
    @(posedge clk iff s_tready);
    w = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6) : 0;
    if (w != 0) begin
      s_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
  endtask

  task automatic settle();
    s_tvalid <= 0;
    @(posedge clk iff pending == 0);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [38:0] rand_layout();
    logic [38:0] l;
    l = 39'({$urandom, $urandom});
    if ($urandom_range(0, 1)) l[11:6] = 6'd0;
    if ($urandom_range(0, 2) == 0) l[5:0] = 6'(8 * $urandom_range(1, 4));
    return l;
  endfunction

  function automatic int dut_h_guess();
    return $urandom_range(0, 1) ? 700 : 2047;
  endfunction

  task automatic rand_config(input bit extreme);
    int h, v;
    h = extreme ? ($urandom_range(0, 1) ? 2048 : $urandom_range(1, 4)) : $urandom_range(1, 600);
    v = extreme ? ($urandom_range(0, 1) ? 2048 : $urandom_range(1, 4)) : $urandom_range(1, 600);
    if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 4095);
    write_reg(REG_H_RES, 39'(h));
    write_reg(REG_V_RES, 39'(v));
    write_reg(REG_INDEXED_MODE, 39'($urandom_range(0, 1)));
    write_reg(REG_RECTANGLES, 39'(extreme ? ($urandom_range(0, 1) ? 255 : $urandom_range(0, 1))
                                          : $urandom_range(1, 20)));
    write_reg(REG_FIRST_COLOR, 39'({$urandom, 1'b0} | 39'($urandom)));
    write_reg(REG_COLOR_STEP, 39'(extreme ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255)));
    write_reg(REG_COLOR_LAYOUT, rand_layout());
  endtask

  initial begin
    rst = 1; s_tvalid = 0; s_tdata = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    // Default registers: corners, tile edges, an inner pixel and out-of-screen pixels.
    send_pixel(0, 0); send_pixel(1023, 767); send_pixel(1024, 0); send_pixel(0, 768);
    send_pixel(2047, 2047); send_pixel(127, 95); send_pixel(128, 96); send_pixel(500, 300);
    settle();
    // Indexed overflow and full 32 bpp mask.
    write_reg(REG_COLOR_LAYOUT, 39'd32);
    write_reg(REG_FIRST_COLOR, 39'hFFFF_FFF0);
    write_reg(REG_COLOR_STEP, 39'd255);
    send_pixel(0, 0); send_pixel(1023, 0); send_pixel(1023, 767);
    settle();
    // Direct mode with wide fields; then zero bytes and zero tiles.
    write_reg(REG_INDEXED_MODE, 39'd0);
    write_reg(REG_COLOR_LAYOUT, {5'd31, 4'd15, 5'd8, 4'd9, 5'd0, 4'd8, 6'd0, 6'd24});
    send_pixel(0, 0); send_pixel(1000, 700); send_pixel(300, 10);
    settle();
    write_reg(REG_COLOR_LAYOUT, 39'd7);
    send_pixel(5, 5);
    settle();
    write_reg(REG_COLOR_LAYOUT, 39'h7F_FFFF_FFFF);
    write_reg(REG_RECTANGLES, 39'd0);
    send_pixel(5, 5);
    settle();
    write_reg(REG_RECTANGLES, 39'd255);
    write_reg(REG_H_RES, 39'd100);
    send_pixel(5, 5); send_pixel(99, 99);
    settle();
    for (phases = 0; phases < 31; phases++) begin
      rand_config(phases % 4 == 0);
      repeat (50) begin
        if ($urandom_range(0, 7) == 0) send_pixel($urandom_range(0, 2047), $urandom_range(0, 2047));
        else send_pixel($urandom_range(0, dut_h_guess()), $urandom_range(0, dut_h_guess()));
      end
      settle();
    end
    $display("Covered %0d configuration phases; %0d written pixels, %0d index errors.",
             phases, seen_writes, seen_errors);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
